/* rtl/core/aligned_stack_allocator_unit_assert.svh */
// assertion macros for the stack allocator
`ifndef ALIGNED_STACK_ALLOCATOR_UNIT_ASSERT_SVH
`define ALIGNED_STACK_ALLOCATOR_UNIT_ASSERT_SVH

// condition holds in the same cycle as its trigger
`define ASA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after its trigger
`define ASA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/asa_pkg.sv */
package asa_pkg;

  localparam int unsigned AddrW        = 40;
  localparam int unsigned LenW         = 41;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned InUseW       = 4;
  localparam int unsigned Align        = 1024;
  localparam int unsigned MaxBlocksDef = 12;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_CAPACITY = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOT_TOP  = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_BASE     = 1'b0,
    CFG_RESERVED = 1'b1
  } cfg_e;

  typedef struct packed {
    op_e              opcode;
    logic [AddrW-1:0] request_bytes;
    logic [AddrW-1:0] release_address;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0]  block_address;
    status_e           status;
    logic [InUseW-1:0] blocks_in_use;
  } rsp_t;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [LenW-1:0]  length;
  } entry_t;

endpackage

/* rtl/core/aligned_stack_allocator_unit.sv */
// Stack (last-in-first-out) allocator over one reserved address region.
// Config port: cfg_we_i writes cfg_data_i into the register chosen by
// cfg_idx_i (base address or reserved size); write only while idle.
// Input channel carries one request item: allocate (request_bytes, rounded
// down to a multiple of 1024 plus one more unit) or free
// (release_address, must be the top block). Output channel returns one
// result item per request: block address, status code, blocks in use.
// An accepted request goes from S_IDLE to S_EXEC; its result is written to
// the output register as soon as that register is free. No new request is
// taken until the previous one leaves S_EXEC.
// in_stall_o is high while a request is being executed. A result waiting
// under out_stall_i does not block acceptance of the next request; that
// request then waits in execution until the output register is taken.
// Reset clears the block count, bytes in use and both registers; the block
// memory needs no clearing since only entries below the count are read.
module aligned_stack_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = asa_pkg::MaxBlocksDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  asa_pkg::cfg_e            cfg_idx_i,
  input  logic [asa_pkg::AddrW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  asa_pkg::req_t            in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output asa_pkg::rsp_t            out_rsp_o
);
  import asa_pkg::*;

  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam logic [LenW-1:0] Slack = LenW'(Align * MAX_BLOCKS);

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [LenW-1:0]   used_q, used_d;
  logic [AddrW-1:0]  base_q, reserved_q;
  req_t              req_q;
  logic              out_valid_q;
  rsp_t              out_rsp_q, rsp_d;

  entry_t            mem [MAX_BLOCKS];
  entry_t            rd_q;
  entry_t            wr_data;
  logic              mem_we, mem_re;
  logic [CntW-1:0]   top_cnt;

  logic              in_acc, out_free, done;
  logic [LenW-1:0]   length, capacity;
  logic [LenW:0]     total;
  logic [CntW+InUseW-1:0] cnt_ext;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign done     = (state_q == S_EXEC) && out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // top entry is fetched when the item is accepted
  assign top_cnt = count_q - CntW'(1);
  assign mem_re  = in_acc && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      reserved_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BASE:     base_q     <= cfg_data_i;
        CFG_RESERVED: reserved_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IdxW-1:0]] <= wr_data;
    end
    if (mem_re) begin
      rd_q <= mem[top_cnt[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_req_i;
    end
  end

  always_comb begin
    // rounding adds one full unit even to exact multiples
    length   = LenW'(req_q.request_bytes & ~AddrW'(Align - 1)) + LenW'(Align);
    total    = {1'b0, used_q} + {1'b0, length};
    capacity = LenW'(reserved_q) + Slack;

    wr_data.start  = base_q + used_q[AddrW-1:0];
    wr_data.length = length;

    mem_we  = 1'b0;
    count_d = count_q;
    used_d  = used_q;
    rsp_d.block_address = '0;
    rsp_d.status        = ST_OK;

    unique case (req_q.opcode)
      OP_ALLOC: begin
        if (count_q == CntW'(MAX_BLOCKS)) begin
          rsp_d.status = ST_FULL;
        end else if (total > {1'b0, capacity}) begin
          rsp_d.status = ST_CAPACITY;
        end else begin
          rsp_d.block_address = wr_data.start;
          mem_we  = done;
          count_d = count_q + CntW'(1);
          used_d  = total[LenW-1:0];
        end
      end
      OP_FREE: begin
        if (count_q == '0) begin
          rsp_d.status = ST_EMPTY;
        end else if (req_q.release_address != rd_q.start) begin
          rsp_d.status = ST_NOT_TOP;
        end else begin
          count_d = top_cnt;
          used_d  = used_q - rd_q.length;
        end
      end
    endcase

    cnt_ext = {{InUseW{1'b0}}, count_d};
    rsp_d.blocks_in_use = cnt_ext[InUseW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !done) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            count_q     <= count_d;
            used_q      <= used_d;
            out_valid_q <= 1'b1;
            out_rsp_q   <= rsp_d;
            state_q     <= S_IDLE;
          end
        end
      endcase
    end
  end

`include "aligned_stack_allocator_unit_assert.svh"

  `ASA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(MAX_BLOCKS), "block count over limit")
  `ASA_ASSERT_NOW(a_empty_no_bytes, count_q == '0, used_q == '0, "bytes in use with no blocks")
  `ASA_ASSERT_NEXT(a_accept_exec, in_acc, state_q == S_EXEC, "accepted item not executed")
  `ASA_ASSERT_NEXT(a_idle_stable, state_q == S_IDLE, $stable(count_q), "count moved while idle")

endmodule
